[rtl/core/lba_pkg.sv]
package lba_pkg;

	localparam int LUMA_W  = 8;
	localparam int DIM_W   = 10;
	localparam int COORD_W = 5;
	localparam int MEAN_W  = 8;

	typedef logic [LUMA_W-1:0]  luma_t;
	typedef logic [DIM_W-1:0]   dim_t;
	typedef logic [COORD_W-1:0] coord_t;
	typedef logic [MEAN_W-1:0]  mean_t;

	// Configuration register indexes.
	typedef enum logic [0:0] {
		CFG_IMAGE_WIDTH  = 1'b0,
		CFG_IMAGE_HEIGHT = 1'b1
	} cfg_reg_t;

	localparam logic [DIM_W-1:0] DIM_RESET = DIM_W'(512);

endpackage

[rtl/core/luma_block_average_unit.sv]
// A block's result passes stage 1, stage 2 and the output register, and may wait in stage 2.
// Throughput: one sample per cycle while pix_ready is high. Column sums are read at intake
// and written in the following cycle; a same-column next sample gets the last write forwarded.
// Input ready drops only while two results are waiting on the output side.
// Reset: both dimension registers go to 512, the pixel position goes to (0,0), and all
// column sums read as zero through per-column valid flops, with no clearing pass.
module luma_block_average_unit #(
	parameter int MAX_WIDTH  = 512,
	parameter int MAX_HEIGHT = 512,
	parameter int BLOCK_SIZE = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  lba_pkg::cfg_reg_t cfg_index,
	input  lba_pkg::dim_t     cfg_data,
	input  logic              pix_valid,
	output logic              pix_ready,
	input  lba_pkg::luma_t    luma,
	input  logic              frame_start,
	output logic              blk_valid,
	input  logic              blk_ready,
	output lba_pkg::mean_t    block_mean,
	output lba_pkg::coord_t   block_col,
	output lba_pkg::coord_t   block_row,
	output logic              last_block
);
	import lba_pkg::*;

	localparam int NUM_COLS = MAX_WIDTH / BLOCK_SIZE;
	localparam int PXW      = $clog2(MAX_WIDTH);
	localparam int PYW      = $clog2(MAX_HEIGHT);
	localparam int SW       = $clog2(BLOCK_SIZE);
	localparam int BXW_R    = $clog2((MAX_WIDTH - 1) / BLOCK_SIZE + 1);
	localparam int BYW_R    = $clog2((MAX_HEIGHT - 1) / BLOCK_SIZE + 1);
	localparam int BXW      = (BXW_R > 1) ? BXW_R : 1;
	localparam int BYW      = (BYW_R > 1) ? BYW_R : 1;
	localparam int AW_R     = $clog2(NUM_COLS);
	localparam int AW       = (AW_R > 1) ? AW_R : 1;
	localparam int XE_R     = $clog2(MAX_WIDTH + 2 * BLOCK_SIZE) + 1;
	localparam int YE_R     = $clog2(MAX_HEIGHT + 2 * BLOCK_SIZE) + 1;
	localparam int XE       = (XE_R > DIM_W + 1) ? XE_R : DIM_W + 1;
	localparam int YE       = (YE_R > DIM_W + 1) ? YE_R : DIM_W + 1;
	localparam int AREA     = BLOCK_SIZE * BLOCK_SIZE;
	localparam int SUM_W    = $clog2(255 * AREA + 1);
	localparam int AREA_LG  = $clog2(AREA);
	localparam int SHIFT    = SUM_W + AREA_LG;
	localparam int PW       = 2 * SUM_W + 1;
	// Rounded-up reciprocal of the block area: exact floor division for any SUM_W-bit sum.
	localparam longint unsigned RECIP_L =
		((64'd1 << SHIFT) + longint'(AREA) - 64'd1) / longint'(AREA);
	localparam logic [SUM_W:0] RECIP = (SUM_W + 1)'(RECIP_L);

	logic [DIM_W-1:0] image_width_q, image_height_q;

	logic [PXW-1:0] pixel_x_q, xbase_q;
	logic [PYW-1:0] pixel_y_q, ybase_q;
	logic [SW-1:0]  sub_x_q, sub_y_q;
	logic [BXW-1:0] bx_q;
	logic [BYW-1:0] by_q;

	logic [PXW-1:0] px, xb;
	logic [PYW-1:0] py, yb;
	logic [SW-1:0]  sx, sy;
	logic [BXW-1:0] bx;
	logic [BYW-1:0] by;
	logic [XE-1:0]  w_raw, w_eff;
	logic [YE-1:0]  h_raw, h_eff;
	logic           x_wrap, y_wrap, in_blk_x, in_blk_y, last_x, last_y, emit_d;
	logic           hsk;

	logic [SUM_W-1:0] sum_mem [NUM_COLS];
	logic [NUM_COLS-1:0] vld_q;

	logic             s1_v_q, s1_inblk, s1_emit, s1_last, s1_eof;
	luma_t            luma_s1;
	logic [AW-1:0]    addr_s1;
	logic [BXW-1:0]   bx_s1;
	logic [BYW-1:0]   by_s1;
	logic [SUM_W-1:0] rdata_s1;

	logic             fwd_v_q;
	logic [AW-1:0]    fwd_addr_q;
	logic [SUM_W-1:0] fwd_data_q;

	logic             fwd_hit, s1_wr, clr_all;
	logic [SUM_W-1:0] prev_sum, new_sum, wdata;

	logic             s2_v_q, s2_last;
	logic [SUM_W-1:0] sum_s2;
	coord_t           col_s2, row_s2;
	logic [PW-1:0]    prod;

	logic   out_v_q, last_q;
	mean_t  mean_q;
	coord_t col_q, row_q;

	logic       out_free, s2_adv;
	logic [1:0] res_cnt;

	// Configuration
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			image_width_q  <= DIM_RESET;
			image_height_q <= DIM_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_IMAGE_WIDTH:  image_width_q  <= cfg_data;
				CFG_IMAGE_HEIGHT: image_height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// A zero dimension acts as one, an oversized one as the maximum.
	always_comb begin
		w_raw = XE'(image_width_q);
		h_raw = YE'(image_height_q);
		if (w_raw == '0)
			w_eff = XE'(1);
		else if (w_raw > XE'(MAX_WIDTH))
			w_eff = XE'(MAX_WIDTH);
		else
			w_eff = w_raw;
		if (h_raw == '0)
			h_eff = YE'(1);
		else if (h_raw > YE'(MAX_HEIGHT))
			h_eff = YE'(MAX_HEIGHT);
		else
			h_eff = h_raw;
	end

	// Intake stage: position of the sample, with frame start forcing (0,0).
	assign hsk = pix_valid && pix_ready;

	always_comb begin
		px = frame_start ? '0 : pixel_x_q;
		xb = frame_start ? '0 : xbase_q;
		sx = frame_start ? '0 : sub_x_q;
		bx = frame_start ? '0 : bx_q;
		py = frame_start ? '0 : pixel_y_q;
		yb = frame_start ? '0 : ybase_q;
		sy = frame_start ? '0 : sub_y_q;
		by = frame_start ? '0 : by_q;

		x_wrap   = (XE'(px) + XE'(1)) >= w_eff;
		y_wrap   = (YE'(py) + YE'(1)) >= h_eff;
		in_blk_x = (XE'(xb) + XE'(BLOCK_SIZE)) <= w_eff;
		in_blk_y = (YE'(yb) + YE'(BLOCK_SIZE)) <= h_eff;
		last_x   = (XE'(xb) + XE'(2 * BLOCK_SIZE)) > w_eff;
		last_y   = (YE'(yb) + YE'(2 * BLOCK_SIZE)) > h_eff;
		emit_d   = in_blk_x && in_blk_y &&
			(sx == SW'(BLOCK_SIZE - 1)) && (sy == SW'(BLOCK_SIZE - 1));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pixel_x_q <= '0;
			xbase_q   <= '0;
			sub_x_q   <= '0;
			bx_q      <= '0;
			pixel_y_q <= '0;
			ybase_q   <= '0;
			sub_y_q   <= '0;
			by_q      <= '0;
		end else if (hsk) begin
			if (x_wrap) begin
				pixel_x_q <= '0;
				xbase_q   <= '0;
				sub_x_q   <= '0;
				bx_q      <= '0;
				if (y_wrap) begin
					pixel_y_q <= '0;
					ybase_q   <= '0;
					sub_y_q   <= '0;
					by_q      <= '0;
				end else begin
					pixel_y_q <= py + 1'b1;
					if (sy == SW'(BLOCK_SIZE - 1)) begin
						sub_y_q <= '0;
						by_q    <= by + 1'b1;
						ybase_q <= PYW'(yb + BLOCK_SIZE);
					end else begin
						sub_y_q <= sy + 1'b1;
						by_q    <= by;
						ybase_q <= yb;
					end
				end
			end else begin
				pixel_x_q <= px + 1'b1;
				pixel_y_q <= py;
				ybase_q   <= yb;
				sub_y_q   <= sy;
				by_q      <= by;
				if (sx == SW'(BLOCK_SIZE - 1)) begin
					sub_x_q <= '0;
					bx_q    <= bx + 1'b1;
					xbase_q <= PXW'(xb + BLOCK_SIZE);
				end else begin
					sub_x_q <= sx + 1'b1;
					bx_q    <= bx;
					xbase_q <= xb;
				end
			end
		end
	end

	// Stage 1: add the sample to its column sum and write it back, or write zero when it closes a block.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			s1_v_q <= 1'b0;
		else
			s1_v_q <= hsk;
	end

	always_ff @(posedge clk) begin
		if (hsk) begin
			luma_s1  <= luma;
			addr_s1  <= bx[AW-1:0];
			bx_s1    <= bx;
			by_s1    <= by;
			s1_inblk <= in_blk_x && in_blk_y;
			s1_emit  <= emit_d;
			s1_last  <= last_x && last_y;
			s1_eof   <= x_wrap && y_wrap;
		end
	end

	always_ff @(posedge clk) begin
		if (hsk && in_blk_x && in_blk_y)
			rdata_s1 <= sum_mem[bx[AW-1:0]];
		if (s1_wr)
			sum_mem[addr_s1] <= wdata;
	end

	// The memory returns old data when the previous sample wrote the same column.
	always_comb begin
		fwd_hit = fwd_v_q && (fwd_addr_q == addr_s1);
		if (!vld_q[addr_s1])
			prev_sum = '0;
		else if (fwd_hit)
			prev_sum = fwd_data_q;
		else
			prev_sum = rdata_s1;
		new_sum = prev_sum + SUM_W'(luma_s1);
		s1_wr   = s1_v_q && s1_inblk;
		wdata   = s1_emit ? '0 : new_sum;
		// A frame start clears ahead of its own sample; a frame end after its last one.
		clr_all = (hsk && frame_start) || (s1_v_q && s1_eof);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q   <= '0;
			fwd_v_q <= 1'b0;
		end else begin
			if (clr_all)
				vld_q <= '0;
			else if (s1_wr)
				vld_q[addr_s1] <= 1'b1;
			fwd_v_q <= s1_wr;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_wr) begin
			fwd_addr_q <= addr_s1;
			fwd_data_q <= wdata;
		end
	end

	// Stage 2 holds the finished sum; the output register holds the mean.
	assign out_free = !out_v_q || blk_ready;
	assign s2_adv   = s2_v_q && out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s2_v_q  <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			if (s1_v_q && s1_inblk && s1_emit)
				s2_v_q <= 1'b1;
			else if (s2_adv)
				s2_v_q <= 1'b0;
			if (s2_adv)
				out_v_q <= 1'b1;
			else if (blk_ready)
				out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_v_q && s1_inblk && s1_emit) begin
			sum_s2  <= new_sum;
			col_s2  <= COORD_W'(bx_s1);
			row_s2  <= COORD_W'(by_s1);
			s2_last <= s1_last;
		end
	end

	assign prod = PW'(sum_s2) * PW'(RECIP);

	always_ff @(posedge clk) begin
		if (s2_adv) begin
			mean_q <= MEAN_W'(prod >> SHIFT);
			col_q  <= col_s2;
			row_q  <= row_s2;
			last_q <= s2_last;
		end
	end

	assign blk_valid  = out_v_q;
	assign block_mean = mean_q;
	assign block_col  = col_q;
	assign block_row  = row_q;
	assign last_block = last_q;

	// Two result slots behind stage 1, so intake stops while two results wait.
	assign res_cnt   = 2'(s1_v_q && s1_inblk && s1_emit) + 2'(s2_v_q) + 2'(out_v_q);
	assign pix_ready = (res_cnt <= 2'd1);

	a_no_result_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_v_q && s1_inblk && s1_emit) |-> (!s2_v_q || s2_adv))
		else $error("result in stage 1 found stage 2 blocked");

	a_result_bound: assert property (@(posedge clk) disable iff (!arst_n)
		$countones({s1_v_q && s1_inblk && s1_emit, s2_v_q, out_v_q}) <= 2)
		else $error("more than two results in flight");

	a_frame_start_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(pix_valid && pix_ready && frame_start) |=> (vld_q == '0))
		else $error("column sums not cleared on frame start");

endmodule
